[hdl/fcg_pkg.sv]
package fcg_pkg;

  // table geometry: 33 points over 0..1
  localparam int unsigned TBL_BITS = 5;
  localparam int unsigned TBL_LAST = 32;
  localparam logic [16:0] UNITY    = 17'd32768;

  // curve selector codes
  typedef enum logic [1:0] {
    CURVE_LIN = 2'd0,
    CURVE_LOG = 2'd1,
    CURVE_EXP = 2'd2,
    CURVE_S   = 2'd3
  } curve_t;

  // configuration register indexes
  localparam logic [1:0] REG_FADE_LENGTH = 2'd0;
  localparam logic [1:0] REG_CURVE_TYPE  = 2'd1;
  localparam logic [1:0] REG_FADE_IN     = 2'd2;

  // classification passed from the front to the divider and shaper
  typedef struct packed {
    logic   unity;    // zero fade length
    logic   clamp_lo; // negative position
    logic   clamp_hi; // position at or beyond length
    curve_t curve;
    logic   fade_in;
  } cls_t;

  function automatic logic [15:0] log_rom(input logic [5:0] i);
    logic [15:0] v;
    begin
      unique case (i)
        6'd0: v = 16'd0;      6'd1: v = 16'd3527;   6'd2: v = 16'd6351;
        6'd3: v = 16'd8707;   6'd4: v = 16'd10727;  6'd5: v = 16'd12496;
        6'd6: v = 16'd14069;  6'd7: v = 16'd15485;  6'd8: v = 16'd16773;
        6'd9: v = 16'd17955;  6'd10: v = 16'd19045; 6'd11: v = 16'd20058;
        6'd12: v = 16'd21004; 6'd13: v = 16'd21890; 6'd14: v = 16'd22725;
        6'd15: v = 16'd23513; 6'd16: v = 16'd24260; 6'd17: v = 16'd24970;
        6'd18: v = 16'd25646; 6'd19: v = 16'd26291; 6'd20: v = 16'd26909;
        6'd21: v = 16'd27500; 6'd22: v = 16'd28068; 6'd23: v = 16'd28615;
        6'd24: v = 16'd29141; 6'd25: v = 16'd29648; 6'd26: v = 16'd30138;
        6'd27: v = 16'd30611; 6'd28: v = 16'd31070; 6'd29: v = 16'd31514;
        6'd30: v = 16'd31944; 6'd31: v = 16'd32362;
        default: v = 16'd32768;
      endcase
      return v;
    end
  endfunction

  function automatic logic [15:0] exp_rom(input logic [5:0] i);
    logic [15:0] v;
    begin
      unique case (i)
        6'd0: v = 16'd0;      6'd1: v = 16'd331;    6'd2: v = 16'd683;
        6'd3: v = 16'd1058;   6'd4: v = 16'd1457;   6'd5: v = 16'd1881;
        6'd6: v = 16'd2334;   6'd7: v = 16'd2815;   6'd8: v = 16'd3327;
        6'd9: v = 16'd3873;   6'd10: v = 16'd4453;  6'd11: v = 16'd5071;
        6'd12: v = 16'd5729;  6'd13: v = 16'd6429;  6'd14: v = 16'd7175;
        6'd15: v = 16'd7968;  6'd16: v = 16'd8813;  6'd17: v = 16'd9712;
        6'd18: v = 16'd10669; 6'd19: v = 16'd11688; 6'd20: v = 16'd12773;
        6'd21: v = 16'd13927; 6'd22: v = 16'd15156; 6'd23: v = 16'd16464;
        6'd24: v = 16'd17857; 6'd25: v = 16'd19340; 6'd26: v = 16'd20918;
        6'd27: v = 16'd22597; 6'd28: v = 16'd24386; 6'd29: v = 16'd26289;
        6'd30: v = 16'd28315; 6'd31: v = 16'd30472;
        default: v = 16'd32768;
      endcase
      return v;
    end
  endfunction

  function automatic logic [15:0] s_rom(input logic [5:0] i);
    logic [15:0] v;
    begin
      unique case (i)
        6'd0: v = 16'd81;     6'd1: v = 16'd118;    6'd2: v = 16'd171;
        6'd3: v = 16'd248;    6'd4: v = 16'd360;    6'd5: v = 16'd521;
        6'd6: v = 16'd753;    6'd7: v = 16'd1084;   6'd8: v = 16'd1554;
        6'd9: v = 16'd2213;   6'd10: v = 16'd3124;  6'd11: v = 16'd4357;
        6'd12: v = 16'd5978;  6'd13: v = 16'd8031;  6'd14: v = 16'd10513;
        6'd15: v = 16'd13347; 6'd16: v = 16'd16384; 6'd17: v = 16'd19421;
        6'd18: v = 16'd22255; 6'd19: v = 16'd24737; 6'd20: v = 16'd26790;
        6'd21: v = 16'd28411; 6'd22: v = 16'd29644; 6'd23: v = 16'd30555;
        6'd24: v = 16'd31214; 6'd25: v = 16'd31684; 6'd26: v = 16'd32015;
        6'd27: v = 16'd32247; 6'd28: v = 16'd32408; 6'd29: v = 16'd32520;
        6'd30: v = 16'd32597; 6'd31: v = 16'd32650;
        default: v = 16'd32687;
      endcase
      return v;
    end
  endfunction

endpackage

[hdl/fcg_front.sv]
// front: captures a word with the live configuration and classifies it
module fcg_front #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [POSITION_BITS:0]   in_position,
  input  logic [POSITION_BITS-1:0] fade_length,
  input  fcg_pkg::curve_t          curve_type,
  input  logic                     fade_in,
  output logic                     f_valid,
  input  logic                     f_stall,
  output logic [POSITION_BITS-1:0] f_pos,
  output logic [POSITION_BITS-1:0] f_len,
  output fcg_pkg::cls_t            f_cls
);

  logic                     vld_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] len_r;
  fcg_pkg::cls_t            cls_r;
  logic                     take;
  logic                     neg;

  assign in_stall = vld_r & f_stall;
  assign take     = in_valid & ~in_stall;
  assign neg      = in_position[POSITION_BITS];

  // output stage of the front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // classification of the word
  always_ff @(posedge clk) begin
    if (take) begin
      pos_r          <= in_position[POSITION_BITS-1:0];
      len_r          <= fade_length;
      cls_r.unity    <= (fade_length == '0);
      cls_r.clamp_lo <= neg;
      cls_r.clamp_hi <= ~neg & (in_position[POSITION_BITS-1:0] >= fade_length);
      cls_r.curve    <= curve_type;
      cls_r.fade_in  <= fade_in;
    end
  end

  assign f_valid = vld_r;
  assign f_pos   = pos_r;
  assign f_len   = len_r;
  assign f_cls   = cls_r;

endmodule

[hdl/fcg_queue.sv]
// short queue between front and back, two entries
module fcg_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_stall,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_stall,
  output logic [WIDTH-1:0] m_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign s_stall = (cnt_r == 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign push    = s_valid & ~s_stall;
  assign pop     = m_valid & ~m_stall;
  assign m_data  = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= s_data;
    end
  end

endmodule

[hdl/fcg_back.sv]
// back: pipelined restoring divider, table interpolation and inversion
module fcg_back #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned PROGRESS_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     b_valid,
  output logic                     b_stall,
  input  logic [POSITION_BITS-1:0] b_pos,
  input  logic [POSITION_BITS-1:0] b_len,
  input  fcg_pkg::cls_t            b_cls,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_gain
);

  localparam int unsigned NS = PROGRESS_BITS;          // one quotient bit per stage
  localparam int unsigned QW = PROGRESS_BITS + 1;
  localparam int unsigned SH = PROGRESS_BITS - fcg_pkg::TBL_BITS;
  localparam int unsigned RW = POSITION_BITS + 1;
  localparam int unsigned NT = NS + 4;                 // load + divider + 3 shaping stages

  logic          adv;
  logic [NT-1:0] vld_r;

  assign adv      = ~(vld_r[NT-1] & out_stall);
  assign b_stall  = ~adv;
  assign out_valid = vld_r[NT-1];

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NT-2:0], b_valid};
    end
  end

  // divider stages: remainder, divisor, partial quotient, class
  logic [RW-1:0]            rem_r [NS+1];
  logic [POSITION_BITS-1:0] dvs_r [NS+1];
  logic [QW-1:0]            quo_r [NS+1];
  fcg_pkg::cls_t            cls_r [NS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {1'b0, b_pos};
      dvs_r[0] <= b_len;
      quo_r[0] <= '0;
      cls_r[0] <= b_cls;
    end
  end

  // for pos < len each shifted remainder stays below twice the divisor; clamped words get their quotient in stage a
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_r[s][RW-2:0], 1'b0};
    assign ge = (sh >= {1'b0, dvs_r[s]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= ge ? (sh - {1'b0, dvs_r[s]}) : sh;
        dvs_r[s+1] <= dvs_r[s];
        quo_r[s+1] <= {quo_r[s][QW-2:0], ge};
        cls_r[s+1] <= cls_r[s];
      end
    end
  end

  // stage a: clamp and table reads
  logic [QW-1:0]   q;
  logic [5:0]      idx;
  logic [15:0]     t0, t1;
  logic [15:0]     t0_r, t1_r;
  logic [SH-1:0]   frac_r;
  logic [QW-1:0]   q_r;
  fcg_pkg::cls_t   ca_r;
  logic            top_r;

  always_comb begin
    if (cls_r[NS].clamp_lo)      q = '0;
    else if (cls_r[NS].clamp_hi) q = QW'(1) << PROGRESS_BITS;
    else                         q = quo_r[NS];
    idx = 6'(q >> SH);
    unique case (cls_r[NS].curve)
      fcg_pkg::CURVE_LOG: begin
        t0 = fcg_pkg::log_rom(idx); t1 = fcg_pkg::log_rom(idx + 6'd1);
      end
      fcg_pkg::CURVE_EXP: begin
        t0 = fcg_pkg::exp_rom(idx); t1 = fcg_pkg::exp_rom(idx + 6'd1);
      end
      fcg_pkg::CURVE_S: begin
        t0 = fcg_pkg::s_rom(idx); t1 = fcg_pkg::s_rom(idx + 6'd1);
      end
      default: begin
        t0 = '0; t1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r   <= t0;
      t1_r   <= t1;
      frac_r <= q[SH-1:0];
      q_r    <= q;
      top_r  <= (idx >= 6'(fcg_pkg::TBL_LAST));
      ca_r   <= cls_r[NS];
    end
  end

  // stage b: interpolation product
  logic [15+SH:0] prod_r;
  logic [15:0]    base_r;
  logic [16:0]    lin_r;
  fcg_pkg::cls_t  cb_r;
  logic [QW+15:0] lin_w;

  assign lin_w = ({16'd0, q_r} << 15) + ((QW+16)'(1) << (PROGRESS_BITS - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= top_r ? '0 : (16+SH)'((t1_r - t0_r) * frac_r);
      base_r <= top_r ? t0_r : t0_r;
      lin_r  <= 17'(lin_w >> PROGRESS_BITS);
      cb_r   <= ca_r;
    end
  end

  // stage c: round, select, clamp, invert
  logic [16:0] g;
  logic [16:0] gc;
  logic [15:0] gain_r;

  always_comb begin
    if (cb_r.curve == fcg_pkg::CURVE_LIN) g = lin_r;
    else g = {1'b0, base_r} +
             17'((prod_r + (16+SH)'(1 << (SH - 1))) >> SH);
    gc = (g > fcg_pkg::UNITY) ? fcg_pkg::UNITY : g;
    if (cb_r.unity)         gc = fcg_pkg::UNITY;
    else if (!cb_r.fade_in) gc = fcg_pkg::UNITY - gc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gain_r <= gc[15:0];
    end
  end

  assign out_gain = gain_r;

endmodule

[hdl/fade_curve_gain_top.sv]
// channel   ports                                   direction
// in        in_valid, in_stall, in_position[24:0]   word in
// out       out_valid, out_stall, out_gain[15:0]    word out
// cfg       cfg_we, cfg_index[1:0], cfg_data[23:0]  register write
//
// one word per cycle sustained while out_stall stays low; a word passes the
// classify register, the queue, the load stage, the restoring divider (one
// quotient bit per stage) and three shaping stages
// reset is synchronous on rst_n and clears valids, queue pointers and the configuration registers
// out_stall with a valid result freezes the back pipeline; the two-entry queue then
// fills and in_stall rises, the front holding its word
module fade_curve_gain_top #(
  parameter int unsigned PROGRESS_BITS = 10,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [POSITION_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [POSITION_BITS:0]   in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_gain
);

  localparam int unsigned QDW = 2 * POSITION_BITS + $bits(fcg_pkg::cls_t);

  logic [POSITION_BITS-1:0] fade_length_r;
  fcg_pkg::curve_t          curve_type_r;
  logic                     fade_in_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_length_r <= '0;
      curve_type_r  <= fcg_pkg::CURVE_LIN;
      fade_in_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcg_pkg::REG_FADE_LENGTH: fade_length_r <= cfg_data;
        fcg_pkg::REG_CURVE_TYPE:  curve_type_r  <= fcg_pkg::curve_t'(cfg_data[1:0]);
        fcg_pkg::REG_FADE_IN:     fade_in_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                     f_valid, f_stall;
  logic [POSITION_BITS-1:0] f_pos, f_len;
  fcg_pkg::cls_t            f_cls;
  logic                     b_valid, b_stall;
  logic [QDW-1:0]           b_data;

  fcg_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_position,
    .fade_length(fade_length_r), .curve_type(curve_type_r), .fade_in(fade_in_r),
    .f_valid, .f_stall, .f_pos, .f_len, .f_cls
  );

  fcg_queue #(.WIDTH(QDW)) u_queue (
    .clk, .rst_n,
    .s_valid(f_valid), .s_stall(f_stall), .s_data({f_pos, f_len, f_cls}),
    .m_valid(b_valid), .m_stall(b_stall), .m_data(b_data)
  );

  fcg_back #(.POSITION_BITS(POSITION_BITS), .PROGRESS_BITS(PROGRESS_BITS)) u_back (
    .clk, .rst_n, .b_valid, .b_stall,
    .b_pos(b_data[QDW-1 -: POSITION_BITS]),
    .b_len(b_data[QDW-POSITION_BITS-1 -: POSITION_BITS]),
    .b_cls(fcg_pkg::cls_t'(b_data[$bits(fcg_pkg::cls_t)-1:0])),
    .out_valid, .out_stall, .out_gain
  );

  // gain never exceeds unity
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain <= 16'd32768))
    else $error("gain above unity");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_gain)))
    else $error("stalled result changed");

  // the front only stalls when the queue is full
  a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (f_valid && f_stall))
    else $error("front stall without full queue");

endmodule

[test/testbench.sv]
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PBITS = 10;
  localparam int unsigned LAT = PBITS + 5;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [24:0] in_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_gain;

  // mirror of the block's registers
  logic [23:0]       span_len;
  fcg_pkg::curve_t   curve_sel;
  logic              rising;

  logic [15:0] gain_q[$];
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 18;
  int unsigned hold_cycles = 0;

  fade_curve_gain_top u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_position(in_position), .out_valid(out_valid), .out_stall(out_stall),
    .out_gain(out_gain)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fade_curve_gain_top test failed");
      $finish;
    end
  end

  // curve tables, sampled at k/32
  function automatic logic [15:0] curve_point(fcg_pkg::curve_t c, int unsigned k);
    int unsigned lg[33] = '{0, 3527, 6351, 8707, 10727, 12496, 14069, 15485, 16773,
      17955, 19045, 20058, 21004, 21890, 22725, 23513, 24260, 24970, 25646, 26291,
      26909, 27500, 28068, 28615, 29141, 29648, 30138, 30611, 31070, 31514, 31944,
      32362, 32768};
    int unsigned ex[33] = '{0, 331, 683, 1058, 1457, 1881, 2334, 2815, 3327, 3873,
      4453, 5071, 5729, 6429, 7175, 7968, 8813, 9712, 10669, 11688, 12773, 13927,
      15156, 16464, 17857, 19340, 20918, 22597, 24386, 26289, 28315, 30472, 32768};
    int unsigned sc[33] = '{81, 118, 171, 248, 360, 521, 753, 1084, 1554, 2213,
      3124, 4357, 5978, 8031, 10513, 13347, 16384, 19421, 22255, 24737, 26790,
      28411, 29644, 30555, 31214, 31684, 32015, 32247, 32408, 32520, 32597, 32650,
      32687};
    case (c)
      fcg_pkg::CURVE_LOG: return 16'(lg[k]);
      fcg_pkg::CURVE_EXP: return 16'(ex[k]);
      default:            return 16'(sc[k]);
    endcase
  endfunction

  // expected fade gain for one position
  function automatic logic [15:0] fade_gain(logic [24:0] pos);
    logic [63:0] q;
    logic [63:0] g;
    logic [63:0] k;
    logic [63:0] lo, hi, fr;
    if (span_len == '0) return 16'd32768;
    if (pos[24]) q = '0;
    else if (pos[23:0] >= span_len) q = 64'd1 << PBITS;
    else q = ({40'd0, pos[23:0]} << PBITS) / {40'd0, span_len};
    if (curve_sel == fcg_pkg::CURVE_LIN) begin
      g = ((q << 15) + (64'd1 << (PBITS - 1))) >> PBITS;
    end else begin
      k = q >> (PBITS - fcg_pkg::TBL_BITS);
      if (k >= 64'(fcg_pkg::TBL_LAST)) begin
        g = {48'd0, curve_point(curve_sel, fcg_pkg::TBL_LAST)};
      end else begin
        lo = {48'd0, curve_point(curve_sel, 32'(k))};
        hi = {48'd0, curve_point(curve_sel, 32'(k + 64'd1))};
        fr = q & ((64'd1 << (PBITS - fcg_pkg::TBL_BITS)) - 64'd1);
        g = lo + ((((hi - lo) * fr) + (64'd1 << (PBITS - fcg_pkg::TBL_BITS - 1)))
            >> (PBITS - fcg_pkg::TBL_BITS));
      end
    end
    if (g > 64'd32768) g = 64'd32768;
    if (!rising) g = 64'd32768 - g;
    return g[15:0];
  endfunction

  // receiver stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [15:0] exp_gain;
    if (rst_n && out_valid && !out_stall) begin
      words_out <= words_out + 1;
      if (gain_q.size() == 0) begin
        $display("%0t: unexpected word, gain %0d", $realtime, out_gain);
        errors <= errors + 1;
      end else begin
        exp_gain = gain_q.pop_front();
        if (exp_gain !== out_gain) begin
          $display("%0t: gain mismatch, expected %0d actual %0d",
                   $realtime, exp_gain, out_gain);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == fcg_pkg::REG_FADE_LENGTH) span_len = val;
    else if (idx == fcg_pkg::REG_CURVE_TYPE) curve_sel = fcg_pkg::curve_t'(val[1:0]);
    else if (idx == fcg_pkg::REG_FADE_IN) rising = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; leaves valid high so words can follow back to back
  task automatic send_word(logic [24:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position <= pos;
    gain_q.push_back(fade_gain(pos));
    words_in++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (gain_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_mode(logic [23:0] len, fcg_pkg::curve_t c, logic dir);
    write_reg(fcg_pkg::REG_FADE_LENGTH, len);
    write_reg(fcg_pkg::REG_CURVE_TYPE, 24'(c));
    write_reg(fcg_pkg::REG_FADE_IN, {23'd0, dir});
  endtask

  function automatic logic [24:0] rand_pos(logic [23:0] len);
    case ($urandom_range(9))
      0: return 25'($urandom);
      1: return -$signed(25'($urandom_range(100)));
      2: return {1'b0, len};
      3: return 25'({1'b0, len} + 25'($urandom_range(3)));
      default: return (len == 0) ? 25'($urandom) : 25'($urandom_range(len));
    endcase
  endfunction

  // reset defaults, unity and extreme positions
  task automatic test_directed;
    int unsigned c;
    send_word(25'd100);
    send_word(25'h1000000);
    drain();
    write_reg(2'd3, 24'hffffff);
    write_reg(fcg_pkg::REG_FADE_LENGTH, 24'hffffff);
    for (c = 0; c < 4; c++) begin
      write_reg(fcg_pkg::REG_CURVE_TYPE, 24'(c));
      send_word(25'd0);
      send_word(25'h0ffffff);
      send_word(25'h0fffffe);
      send_word(25'h07fffff);
      send_word(25'h1ffffff);
      drain();
    end
    set_mode(24'd1, fcg_pkg::CURVE_S, 1'b0);
    send_word(25'd0);
    send_word(25'd1);
    send_word(25'h0ffffff);
    drain();
    set_mode(24'd0, fcg_pkg::CURVE_LOG, 1'b0);
    send_word(25'd5);
    send_word(25'h1555555);
    drain();
  endtask

  // random sweep over settings, with a free-running stretch
  task automatic test_random;
    int unsigned ph, n;
    logic [23:0] len;
    for (ph = 0; ph < 28; ph++) begin
      case (ph % 4)
        0: len = 24'($urandom_range(2000, 1));
        1: len = 24'($urandom);
        2: len = 24'($urandom_range(40, 1));
        default: len = (ph == 3) ? 24'hffffff : 24'($urandom_range(5000));
      endcase
      set_mode(len, fcg_pkg::curve_t'($urandom_range(3)), 1'($urandom_range(1)));
      idle_pct = (ph == 10 || ph == 11) ? 0 : 18;
      for (n = 0; n < 50; n++) send_word(rand_pos(len));
      drain();
    end
    idle_pct = 18;
  endtask

  // long receiver hold so the pipeline backs up
  task automatic test_backpressure;
    int unsigned n;
    set_mode(24'd777, fcg_pkg::CURVE_EXP, 1'b1);
    @(posedge clk);
    hold_cycles = 60;
    for (n = 0; n < 40; n++) send_word(rand_pos(24'd777));
    drain();
  endtask

  initial begin
    span_len = '0;
    curve_sel = fcg_pkg::CURVE_LIN;
    rising = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    $display("covered %0d words in, %0d out, all curves and both directions,",
             words_in, words_out);
    $display("span lengths from zero to full scale, with idling and a long hold");
    if (errors == 0 && gain_q.size() == 0) begin
      $display("fade_curve_gain_top test passed");
    end else begin
      $display("fade_curve_gain_top test failed");
    end
    $finish;
  end

endmodule
